FILE: hdl/pcg_pkg.sv
// Package for the PCG32 bounded random source: widths, constants, request modes.
// No dependencies.
package pcg_pkg;
	localparam int StateW = 64;
	localparam int WordW = 32;
	localparam int ModeW = 3;
	localparam logic [63:0] LcgMul = 64'd6364136223846793005;
	localparam logic [63:0] LcgAdd = 64'd1442695040888963407;
	localparam logic [63:0] LcgReset = 64'h853c49e6748fea9b;

	typedef enum logic [2:0] {
		MODE_RAW = 3'd0, MODE_SEED = 3'd1, MODE_LOAD = 3'd2, MODE_READ = 3'd3,
		MODE_UBND = 3'd4, MODE_SBND = 3'd5, MODE_BOOL = 3'd6, MODE_NONE = 3'd7
	} mode_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [63:0] seed_or_state;
		logic [31:0] low_bound;
		logic [31:0] high_bound;
		logic include_low;
		logic include_high;
	} req_t;

	typedef struct packed {
		logic [31:0] value;
		logic [63:0] state_after;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_state;
		logic load_state;
		logic add_seed;
		logic mul_start;  // start LCG multiply/output word
		logic step;       // commit step, capture word
		logic mod_start;  // start r % span
		logic lim_start;  // start limit = (-span) % span
		logic set_val_word;
		logic set_val_bool;
		logic set_val_zero;
		logic set_val_lo;
		logic set_val_mod;
		logic out_load;   // copy value and state into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic empty;      // range empty or guard hit
		logic full_span;
		logic reject;     // word < limit
	} sts_t;
endpackage

FILE: hdl/pcg_if.sv
// Valid/ready channel interface carrying one word of payload type T.
// Depends on nothing; payload types come from pcg_pkg.
interface pcg_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/pcg32_bounded_random_source_top.sv
// PCG32 (XSH RR) random source with raw, seed, load, read, boolean and bounded draws.
// A raw, boolean or full-span draw makes one LCG step with the split 64-bit multiply,
// a seed makes two steps, and a bounded draw adds the bit-serial modulo unit, which
// computes the rejection limit and the final remainder, and repeats the step for each
// rejected attempt. Load, read, unused and empty-range requests make no step. The next
// request can be taken in the same cycle as the result word is presented; a pending
// word only holds the controller at its end.
// Depends on pcg_pkg, pcg_if, pcg_ctrl, pcg_datapath.
module pcg32_bounded_random_source_top (
	input logic clk,
	input logic arst_n,
	pcg_if.sink req,
	pcg_if.source rsp
);
	pcg_pkg::cmd_t cmd;
	pcg_pkg::sts_t sts;
	logic take;

	pcg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_mode(req.data.mode),
		.take(take), .out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd), .sts(sts)
	);

	pcg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .take(take), .cmd(cmd),
		.req(req.data), .sts(sts), .rsp(rsp.data)
	);

`ifndef SYNTH
	a_accept_once: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready) else $error("back to back accept");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result word dropped");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.set_val_word, cmd.set_val_bool, cmd.set_val_zero,
			cmd.set_val_lo, cmd.set_val_mod})) else $error("value select clash");
`endif
endmodule

FILE: hdl/pcg_datapath.sv
// Datapath: LCG state, split 64-bit multiply, XSH RR output, bounds, serial modulo.
// Depends on pcg_pkg.
module pcg_datapath (
	input logic clk,
	input logic arst_n,
	input logic take,
	input pcg_pkg::cmd_t cmd,
	input pcg_pkg::req_t req,
	output pcg_pkg::sts_t sts,
	output pcg_pkg::rsp_t rsp
);
	logic [63:0] state_q;
	logic [63:0] seed_q;
	logic [31:0] lo_q, span_q, word_q, limit_q, value_q, res_q;
	logic empty_q, full_q;
	pcg_pkg::rsp_t out_q;
	// multiply: three 32x32 partial products, one per cycle
	logic [1:0] mph_q;
	logic mbusy_q;
	logic [63:0] prod_q;
	logic [31:0] ma, mb;
	logic [63:0] pp;
	// serial divider
	logic [32:0] rem_q;
	logic [31:0] dvd_q;
	logic [5:0] dcnt_q;
	logic dbusy_q;
	logic [32:0] trial;

	// bounds
	logic sgn;
	logic [31:0] ka, kb, a1, b1, a2, b2;
	logic g_empty;
	always_comb begin
		sgn = (req.mode == pcg_pkg::MODE_SBND);
		ka = req.low_bound ^ {sgn, 31'd0};
		kb = req.high_bound ^ {sgn, 31'd0};
		a1 = (ka > kb) ? kb : ka;
		b1 = (ka > kb) ? ka : kb;
		g_empty = 1'b0;
		a2 = a1;
		b2 = b1;
		if (!req.include_low) begin
			if (sgn && a1 == 32'hffffffff) g_empty = 1'b1;
			else a2 = a1 + 32'd1;
		end
		if (!req.include_high && !g_empty) begin
			if (sgn && b1 == 32'd0) begin
				g_empty = 1'b1;
				a2 = b1;
			end else b2 = b1 - 32'd1;
		end
		if (!g_empty && b2 < a2) g_empty = 1'b1;
	end

	always_comb begin
		case (mph_q)
			2'd0: begin ma = state_q[31:0]; mb = pcg_pkg::LcgMul[31:0]; end
			2'd1: begin ma = state_q[63:32]; mb = pcg_pkg::LcgMul[31:0]; end
			default: begin ma = state_q[31:0]; mb = pcg_pkg::LcgMul[63:32]; end
		endcase
		pp = ma * mb;
	end

	logic [31:0] xs, word_n;
	logic [4:0] rot;
	always_comb begin
		xs = 32'(((state_q >> 18) ^ state_q) >> 27);
		rot = state_q[63:59];
		word_n = (xs >> rot) | (xs << ((5'd0 - rot) & 5'd31));
		trial = {rem_q[31:0], dvd_q[31]} - {1'b0, span_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcg_pkg::LcgReset;
			mbusy_q <= 1'b0;
			mph_q <= 2'd0;
			dbusy_q <= 1'b0;
			dcnt_q <= 6'd0;
			out_q <= '0;
		end else begin
			if (take) begin
				seed_q <= req.seed_or_state;
				lo_q <= a2 ^ {sgn, 31'd0};
				span_q <= b2 - a2 + 32'd1;
				full_q <= (b2 - a2 + 32'd1) == 32'd0;
				empty_q <= g_empty;
			end
			if (cmd.clr_state) state_q <= 64'd0;
			if (cmd.load_state) state_q <= seed_q;
			if (cmd.add_seed) state_q <= state_q + seed_q;
			if (cmd.mul_start) begin
				mbusy_q <= 1'b1;
				mph_q <= 2'd0;
				prod_q <= 64'd0;
			end else if (mbusy_q) begin
				case (mph_q)
					2'd0: prod_q <= pp;
					default: prod_q <= {prod_q[63:32] + pp[31:0], prod_q[31:0]};
				endcase
				if (mph_q == 2'd2) mbusy_q <= 1'b0;
				mph_q <= mph_q + 2'd1;
			end
			if (cmd.step) begin
				word_q <= word_n;
				state_q <= prod_q + pcg_pkg::LcgAdd;
			end
			if (cmd.lim_start) begin
				dbusy_q <= 1'b1;
				dcnt_q <= 6'd32;
				dvd_q <= 32'd0 - span_q;
				rem_q <= 33'd0;
			end else if (cmd.mod_start) begin
				dbusy_q <= 1'b1;
				dcnt_q <= 6'd32;
				dvd_q <= word_q;
				rem_q <= 33'd0;
			end else if (dbusy_q) begin
				if (!trial[32]) rem_q <= trial;
				else rem_q <= {rem_q[31:0], dvd_q[31]};
				dvd_q <= {dvd_q[30:0], 1'b0};
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1) dbusy_q <= 1'b0;
			end
			if (cmd.lim_start) limit_q <= 32'd0;
			else if (dbusy_q && dcnt_q == 6'd1 && !cmd.mod_start) res_q <= trial[32] ?
				{rem_q[30:0], dvd_q[31]} : trial[31:0];
			if (cmd.set_val_word) value_q <= word_q;
			if (cmd.set_val_bool) value_q <= {31'd0, word_q[31]};
			if (cmd.set_val_zero) value_q <= 32'd0;
			if (cmd.set_val_lo) value_q <= lo_q;
			if (cmd.set_val_mod) value_q <= lo_q + res_q;
			if (cmd.step) limit_q <= res_q;
			if (cmd.out_load) begin
				out_q.value <= value_q;
				out_q.state_after <= state_q;
			end
		end
	end

	// limit_q is loaded from res_q at every step, first at the step after the limit division
	logic lim_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lim_valid_q <= 1'b0;
		else if (take) lim_valid_q <= 1'b0;
		else if (cmd.step) lim_valid_q <= 1'b1;
	end

	always_comb begin
		sts.mul_done = !mbusy_q && !cmd.mul_start;
		sts.div_done = !dbusy_q;
		sts.empty = empty_q;
		sts.full_span = full_q;
		sts.reject = word_q < (lim_valid_q ? limit_q : res_q);
		rsp = out_q;
	end
endmodule

FILE: hdl/pcg_ctrl.sv
// Controller FSM: sequences mode handling, steps, rejection loop and output word.
// Depends on pcg_pkg.
module pcg_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] in_mode,
	output logic take,
	output logic out_valid,
	input logic out_ready,
	output pcg_pkg::cmd_t cmd,
	input pcg_pkg::sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_MUL, S_STEP, S_LIMIT, S_LIMWAIT, S_CHECK,
		S_MOD, S_MODWAIT, S_SEED2, S_DONE, S_OUT
	} state_t;
	state_t st_q;
	logic [2:0] mode_q;
	logic seed_phase_q;
	logic out_valid_q;

	assign in_ready = (st_q == S_IDLE);
	assign take = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			mode_q <= pcg_pkg::MODE_NONE;
			seed_phase_q <= 1'b0;
			out_valid_q <= 1'b0;
			cmd <= '0;
		end else begin
			cmd <= '0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: if (take) begin
					mode_q <= in_mode;
					st_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					case (mode_q)
						pcg_pkg::MODE_RAW, pcg_pkg::MODE_BOOL: begin
							cmd.mul_start <= 1'b1;
							st_q <= S_MUL;
						end
						pcg_pkg::MODE_SEED: begin
							cmd.clr_state <= 1'b1;
							seed_phase_q <= 1'b0;
							st_q <= S_SEED2;
						end
						pcg_pkg::MODE_LOAD: begin
							cmd.load_state <= 1'b1;
							cmd.set_val_zero <= 1'b1;
							st_q <= S_DONE;
						end
						pcg_pkg::MODE_UBND, pcg_pkg::MODE_SBND: begin
							if (sts.empty) begin
								cmd.set_val_lo <= 1'b1;
								st_q <= S_DONE;
							end else if (sts.full_span) begin
								cmd.mul_start <= 1'b1;
								st_q <= S_MUL;
							end else begin
								cmd.lim_start <= 1'b1;
								st_q <= S_LIMIT;
							end
						end
						default: begin
							cmd.set_val_zero <= 1'b1;
							st_q <= S_DONE;
						end
					endcase
				end
				S_SEED2: begin
					cmd.mul_start <= 1'b1;
					st_q <= S_MUL;
				end
				S_LIMIT: st_q <= S_LIMWAIT;
				S_LIMWAIT: if (sts.div_done) begin
					cmd.mul_start <= 1'b1;
					st_q <= S_MUL;
				end
				S_MUL: if (sts.mul_done) begin
					cmd.step <= 1'b1;
					st_q <= S_STEP;
				end
				S_STEP: begin
					case (mode_q)
						pcg_pkg::MODE_RAW: begin
							cmd.set_val_word <= 1'b1;
							st_q <= S_DONE;
						end
						pcg_pkg::MODE_BOOL: begin
							cmd.set_val_bool <= 1'b1;
							st_q <= S_DONE;
						end
						pcg_pkg::MODE_SEED: begin
							if (!seed_phase_q) begin
								cmd.add_seed <= 1'b1;
								seed_phase_q <= 1'b1;
								st_q <= S_SEED2;
							end else begin
								cmd.set_val_zero <= 1'b1;
								st_q <= S_DONE;
							end
						end
						default: begin
							if (sts.full_span) begin
								cmd.set_val_word <= 1'b1;
								st_q <= S_DONE;
							end else st_q <= S_CHECK;
						end
					endcase
				end
				S_CHECK: begin
					if (sts.reject) begin
						cmd.mul_start <= 1'b1;
						st_q <= S_MUL;
					end else begin
						cmd.mod_start <= 1'b1;
						st_q <= S_MOD;
					end
				end
				S_MOD: st_q <= S_MODWAIT;
				S_MODWAIT: if (sts.div_done) begin
					cmd.set_val_mod <= 1'b1;
					st_q <= S_DONE;
				end
				// wait until the output register is free
				S_DONE: if (!out_valid_q || out_ready) begin
					cmd.out_load <= 1'b1;
					st_q <= S_OUT;
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
